// File: src/vtpd_pkg.sv
`timescale 1ns / 1ps
package vtpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int ACC_W     = PROD_W + 2 - FRAC_BITS;
    localparam int MAG_W     = ACC_W - 1;
    localparam int LOW_W     = COORD_W - FRAC_BITS;
    localparam int DIV_STEPS = COORD_W;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;
    localparam int MQ_DEPTH  = 4;
    localparam int MQ_PTR_W  = $clog2(MQ_DEPTH);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [CFG_W-1:0]          cfg_word_t;
    typedef cfg_word_t [NUM_REGS-1:0]  cfg_bank_t;

    localparam cfg_word_t ONE_LO = cfg_word_t'(64'd1 << FRAC_BITS);
    localparam cfg_word_t ONE_HI = cfg_word_t'(64'd1 << (FRAC_BITS + COORD_W));

    localparam cfg_bank_t CFG_RESET = '{ONE_HI, '0, ONE_LO, '0, '0, ONE_HI, '0, ONE_LO};

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
    } point_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   w_was_zero;
        logic   saturated;
    } result_t;

    typedef struct packed {
        mag_t [2:0] num;
        mag_t       den;
        logic [2:0] num_neg;
        logic       den_neg;
        logic       w_zero;
    } mid_t;

endpackage

// File: src/vtpd_queue.sv
`timescale 1ns / 1ps
module vtpd_queue
    import vtpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  mid_t wdata,
    output logic full,
    input  logic rd,
    output mid_t rdata,
    output logic empty
);

    mid_t                mem_reg [MQ_DEPTH];
    logic [MQ_PTR_W-1:0] wr_ptr_reg;
    logic [MQ_PTR_W-1:0] rd_ptr_reg;
    logic [MQ_PTR_W:0]   count_reg;
    logic [MQ_PTR_W:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign full  = (count_reg == (MQ_PTR_W+1)'(MQ_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: src/vtpd_front.sv
`timescale 1ns / 1ps
module vtpd_front
    import vtpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_bank_t mat_cfg,
    input  logic      push,
    output logic      full,
    input  point_t    point,
    output logic      mid_push,
    input  logic      mid_full,
    output mid_t      mid_data
);

    logic signed [PROD_W-1:0] prod_reg [3][4];
    logic signed [ACC_W-1:0]  acc_reg [4];
    logic signed [ACC_W-1:0]  acc_next [4];
    mid_t                     mid_reg;
    mid_t                     mid_next;
    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     s3_valid_reg;
    logic                     adv;
    coord_t                   pin [3];
    coord_t                   mat [4][4];

    assign pin[0] = point.point_x;
    assign pin[1] = point.point_y;
    assign pin[2] = point.point_z;

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign mat[r][c] = coord_t'(mat_cfg[r*2 + c/2][(c%2)*COORD_W +: COORD_W]);
        end
    end

    assign adv      = !(s3_valid_reg && mid_full);
    assign full     = !adv;
    assign mid_push = adv && s3_valid_reg;
    assign mid_data = mid_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            acc_next[c] = ACC_W'(mat[3][c])
                        + ACC_W'($signed(prod_reg[0][c][PROD_W-1:FRAC_BITS]))
                        + ACC_W'($signed(prod_reg[1][c][PROD_W-1:FRAC_BITS]))
                        + ACC_W'($signed(prod_reg[2][c][PROD_W-1:FRAC_BITS]));
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mid_next.num_neg[c] = acc_reg[c][ACC_W-1];
            mid_next.num[c]     = acc_reg[c][ACC_W-1] ? MAG_W'(-acc_reg[c])
                                                      : MAG_W'(acc_reg[c]);
        end
        mid_next.den_neg = acc_reg[3][ACC_W-1];
        mid_next.den     = acc_reg[3][ACC_W-1] ? MAG_W'(-acc_reg[3]) : MAG_W'(acc_reg[3]);
        mid_next.w_zero  = (acc_reg[3] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= push;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= PROD_W'(pin[r]) * PROD_W'(mat[r][c]);
                end
            end
            acc_reg <= acc_next;
            mid_reg <= mid_next;
        end
    end

endmodule

// File: src/vtpd_back.sv
`timescale 1ns / 1ps
module vtpd_back
    import vtpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    mid_empty,
    output logic    mid_pop,
    input  mid_t    mid_data,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    typedef struct packed {
        mag_t [2:0]               rem;
        logic [2:0][COORD_W-1:0]  low;
        logic [2:0][COORD_W-1:0]  quo;
        mag_t                     den;
        logic [2:0]               ovf;
        logic [2:0]               num_neg;
        logic                     den_neg;
        logic                     w_zero;
    } div_t;

    localparam coord_t MAX_V = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t MIN_V = {1'b1, {(COORD_W-1){1'b0}}};

    div_t                 st_reg [DIV_STEPS+1];
    div_t                 st_next [DIV_STEPS+1];
    logic [DIV_STEPS:0]   st_valid_reg;
    logic                 adv;
    result_t              res_next;
    coord_t               val [3];
    logic [2:0]           sat;
    result_t              oq_reg [2];
    logic                 oq_wr_reg;
    logic                 oq_rd_reg;
    logic [1:0]           oq_count_reg;
    logic                 oq_push;
    logic                 oq_pop;

    assign adv     = !(st_valid_reg[DIV_STEPS] && oq_count_reg == 2'd2);
    assign mid_pop = adv && !mid_empty;
    assign oq_push = adv && st_valid_reg[DIV_STEPS];
    assign oq_pop  = pop && oq_count_reg != 2'd0;
    assign empty   = (oq_count_reg == 2'd0);
    assign result  = oq_reg[oq_rd_reg];

    always_comb
    begin
        st_next[0] = st_reg[0];
        st_next[0].den     = mid_data.den;
        st_next[0].num_neg = mid_data.num_neg;
        st_next[0].den_neg = mid_data.den_neg;
        st_next[0].w_zero  = mid_data.w_zero;
        for (int c = 0; c < 3; c++)
        begin
            st_next[0].rem[c] = MAG_W'(mid_data.num[c] >> LOW_W);
            st_next[0].low[c] = {mid_data.num[c][LOW_W-1:0], {FRAC_BITS{1'b0}}};
            if (mid_data.w_zero)
            begin
                st_next[0].ovf[c] = mid_data.num_neg[c]
                    ? ((MAG_W+1)'(mid_data.num[c]) > (MAG_W+1)'(64'h8000_0000))
                    : ((MAG_W+1)'(mid_data.num[c]) > (MAG_W+1)'(64'h7FFF_FFFF));
                st_next[0].quo[c] = mid_data.num_neg[c]
                    ? COORD_W'(-mid_data.num[c]) : COORD_W'(mid_data.num[c]);
            end
            else
            begin
                st_next[0].ovf[c] = (MAG_W+FRAC_BITS)'(mid_data.num[c])
                                    >= {mid_data.den, {FRAC_BITS{1'b0}}};
                st_next[0].quo[c] = '0;
            end
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [MAG_W:0] trial [3];
        always_comb
        begin
            st_next[k] = st_reg[k-1];
            for (int c = 0; c < 3; c++)
            begin
                trial[c] = {st_reg[k-1].rem[c], st_reg[k-1].low[c][COORD_W-1]};
                if (!st_reg[k-1].w_zero)
                begin
                    st_next[k].low[c] = {st_reg[k-1].low[c][COORD_W-2:0], 1'b0};
                    if (trial[c] >= {1'b0, st_reg[k-1].den})
                    begin
                        st_next[k].rem[c] = MAG_W'(trial[c] - {1'b0, st_reg[k-1].den});
                        st_next[k].quo[c] = {st_reg[k-1].quo[c][COORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        st_next[k].rem[c] = MAG_W'(trial[c]);
                        st_next[k].quo[c] = {st_reg[k-1].quo[c][COORD_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic neg;
            logic [COORD_W-1:0] q;
            neg = st_reg[DIV_STEPS].num_neg[c] ^ st_reg[DIV_STEPS].den_neg;
            q   = st_reg[DIV_STEPS].quo[c];
            sat[c] = 1'b0;
            if (st_reg[DIV_STEPS].w_zero)
            begin
                sat[c] = st_reg[DIV_STEPS].ovf[c];
                val[c] = st_reg[DIV_STEPS].ovf[c]
                    ? (st_reg[DIV_STEPS].num_neg[c] ? MIN_V : MAX_V) : coord_t'(q);
            end
            else if (st_reg[DIV_STEPS].ovf[c] || q > 32'h8000_0000)
            begin
                sat[c] = 1'b1;
                val[c] = neg ? MIN_V : MAX_V;
            end
            else if (neg)
            begin
                val[c] = coord_t'(-q);
            end
            else if (q[COORD_W-1])
            begin
                sat[c] = 1'b1;
                val[c] = MAX_V;
            end
            else
            begin
                val[c] = coord_t'(q);
            end
        end
        res_next.out_x      = val[0];
        res_next.out_y      = val[1];
        res_next.out_z      = val[2];
        res_next.w_was_zero = st_reg[DIV_STEPS].w_zero;
        res_next.saturated  = |sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= '0;
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                st_valid_reg <= {st_valid_reg[DIV_STEPS-1:0], !mid_empty};
            end
            if (oq_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            if (oq_push && !oq_pop)
            begin
                oq_count_reg <= oq_count_reg + 1'b1;
            end
            else if (oq_pop && !oq_push)
            begin
                oq_count_reg <= oq_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= res_next;
        end
    end

endmodule

// File: src/vertex_transform_perspective_divide.sv
`timescale 1ns / 1ps
// Throughput: one point per cycle while nothing stalls; set by the 3-stage multiply/sum front end
// and the 32-stage restoring divider, one quotient bit per stage per lane.
// Reset: queues and pipelines empty, matrix set to identity.
module vertex_transform_perspective_divide
    import vtpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  point_t               point,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  cfg_word_t            cfg_data
);

    cfg_bank_t cfg_reg;
    logic      mid_push;
    logic      mid_full;
    mid_t      mid_wdata;
    logic      mid_pop;
    logic      mid_empty;
    mid_t      mid_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS))
        begin
            cfg_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    vtpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .mat_cfg  (cfg_reg),
        .push     (push),
        .full     (full),
        .point    (point),
        .mid_push (mid_push),
        .mid_full (mid_full),
        .mid_data (mid_wdata)
    );

    vtpd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .rd    (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    vtpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_data  (mid_rdata),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// File: bench/tb_vertex_transform_perspective_divide.sv
`timescale 1ns / 1ps
module tb_vertex_transform_perspective_divide;
    import vtpd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_A = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_B = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_A = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_B = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_A = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_B = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_A = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_B = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 4'd15;
    localparam int    ITEMS_PER_PHASE = 220;
    localparam int    SETTLE_CYCLES   = 60;
    localparam int    CYCLE_LIMIT     = 400000;
    localparam coord_t C_MAX = 32'sh7FFFFFFF;
    localparam coord_t C_MIN = 32'sh80000000;

    class vertex_scoreboard;
        cfg_word_t bank [NUM_REGS];
        result_t   pending [$];

        function new();
            for (int i = 0; i < NUM_REGS; i++)
                bank[i] = CFG_RESET[i];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t data);
            if (idx < NUM_REGS)
                bank[idx] = data;
        endfunction

        function coord_t entry(int r, int c);
            cfg_word_t word;
            word = bank[r * 2 + c / 2];
            return (c % 2) ? coord_t'(word[63:32]) : coord_t'(word[31:0]);
        endfunction

        function result_t project(point_t p);
            longint acc [4];
            coord_t pc [3];
            logic signed [127:0] num;
            logic signed [127:0] den;
            logic signed [127:0] v;
            result_t r;
            pc[0] = p.point_x;
            pc[1] = p.point_y;
            pc[2] = p.point_z;
            for (int c = 0; c < 4; c++)
            begin
                acc[c] = longint'(entry(3, c));
                for (int k = 0; k < 3; k++)
                    acc[c] += (longint'(pc[k]) * longint'(entry(k, c))) >>> FRAC_BITS;
            end
            r = '0;
            r.w_was_zero = (acc[3] == 0);
            for (int c = 0; c < 3; c++)
            begin
                num = acc[c];
                den = acc[3];
                if (r.w_was_zero)
                    v = num;
                else
                    v = (num <<< FRAC_BITS) / den;
                if (v > 128'sd2147483647)
                begin
                    v = 128'sd2147483647;
                    r.saturated = 1'b1;
                end
                else if (v < -128'sd2147483648)
                begin
                    v = -128'sd2147483648;
                    r.saturated = 1'b1;
                end
                case (c)
                    0: r.out_x = coord_t'(v[31:0]);
                    1: r.out_y = coord_t'(v[31:0]);
                    default: r.out_z = coord_t'(v[31:0]);
                endcase
            end
            return r;
        endfunction

        function void note_point(point_t p);
            pending.push_back(project(p));
        endfunction

        function string check_result(result_t got);
            result_t want;
            string msg;
            if (pending.size() == 0)
                return $sformatf("result %h with none outstanding", got);
            want = pending.pop_front();
            msg = "";
            if (got.out_x !== want.out_x)
                msg = {msg, $sformatf(" out_x %h/%h", got.out_x, want.out_x)};
            if (got.out_y !== want.out_y)
                msg = {msg, $sformatf(" out_y %h/%h", got.out_y, want.out_y)};
            if (got.out_z !== want.out_z)
                msg = {msg, $sformatf(" out_z %h/%h", got.out_z, want.out_z)};
            if (got.w_was_zero !== want.w_was_zero)
                msg = {msg, $sformatf(" w_was_zero %b/%b", got.w_was_zero, want.w_was_zero)};
            if (got.saturated !== want.saturated)
                msg = {msg, $sformatf(" saturated %b/%b", got.saturated, want.saturated)};
            return msg;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    point_t               point;
    logic                 empty;
    logic                 pop;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    cfg_word_t            cfg_data;

    vertex_scoreboard sb;
    int  errors;
    int  cycles;
    bit  calm;

    vertex_transform_perspective_divide dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .point     (point),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(string msg);
        errors++;
        $display("MISMATCH at cycle %0d:%s", cycles, msg);
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 31);
    endfunction

    always @(posedge clk)
    begin
        string msg;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            if (rst_n && pop && !empty)
            begin
                msg = sb.check_result(result);
                if (msg != "")
                    report(msg);
            end
            pop <= rst_n && !idle_now();
        end
    end

    task automatic send_point(point_t p);
        while (idle_now())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (full);
        sb.note_point(p);
    endtask

    task automatic stop_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_matrix(coord_t m [4][4]);
        write_reg(REG_ROW0_A, {m[0][1], m[0][0]});
        write_reg(REG_ROW0_B, {m[0][3], m[0][2]});
        write_reg(REG_ROW1_A, {m[1][1], m[1][0]});
        write_reg(REG_ROW1_B, {m[1][3], m[1][2]});
        write_reg(REG_ROW2_A, {m[2][1], m[2][0]});
        write_reg(REG_ROW2_B, {m[2][3], m[2][2]});
        write_reg(REG_ROW3_A, {m[3][1], m[3][0]});
        write_reg(REG_ROW3_B, {m[3][3], m[3][2]});
        write_reg(REG_SPARE ^ CFG_IDX_W'($urandom_range(7)), {$urandom, $urandom});
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return coord_t'($signed($urandom_range(32'h1FFFFF)) - 32'sh100000);
            6, 7: return coord_t'($urandom);
            8:
            begin
                case ($urandom_range(4))
                    0: return 32'sd0;
                    1: return 32'sd1;
                    2: return -32'sd1;
                    3: return C_MAX;
                    default: return C_MIN;
                endcase
            end
            default: return coord_t'($signed($urandom_range(32'h1FFFFFF)) - 32'sh1000000);
        endcase
    endfunction

    task automatic run_random(int n);
        point_t p;
        for (int i = 0; i < n; i++)
        begin
            p.point_x = pick_coord();
            p.point_y = pick_coord();
            p.point_z = pick_coord();
            send_point(p);
        end
        stop_push();
        drain();
    endtask

    initial
    begin
        coord_t m [4][4];
        point_t p;
        coord_t edges [6];
        sb = new();
        errors    = 0;
        cycles    = 0;
        calm      = 1'b0;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        pop       <= 1'b0;
        point     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        edges = '{32'sd0, 32'sd1, -32'sd1, C_MAX, C_MIN, 32'sh00010000};
        for (int i = 0; i < 6; i++)
        begin
            p = '{edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]};
            send_point(p);
        end
        stop_push();
        drain();

        // perspective: w follows z, so z = 0 gives a zero w
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == c && r < 3) ? 32'sh00010000 : 32'sd0;
        m[2][3] = 32'sh00010000;
        write_matrix(m);
        edges = '{32'sd0, 32'sh00010000, -32'sh00010000, C_MAX, C_MIN, 32'sd1};
        for (int i = 0; i < 12; i++)
        begin
            p = '{edges[i % 6], edges[(i + 2) % 6], (i < 4) ? 32'sd0 : edges[(i + 4) % 6]};
            send_point(p);
        end
        stop_push();
        drain();

        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = coord_t'($signed($urandom_range(32'h7FFFF)) - 32'sh40000);
        write_matrix(m);
        run_random(ITEMS_PER_PHASE);

        calm = 1'b1;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = coord_t'($urandom);
        write_matrix(m);
        run_random(ITEMS_PER_PHASE);
        calm = 1'b0;

        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = ((r + c) % 2) ? C_MAX : C_MIN;
        write_matrix(m);
        run_random(ITEMS_PER_PHASE);

        // zero w column: undivided values pass through
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (c == 3) ? 32'sd0 : coord_t'($urandom);
        write_matrix(m);
        run_random(ITEMS_PER_PHASE);

        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == c) ? 32'sh00010000 : 32'sd0;
        m[3][3] = 32'sh00020000;
        m[3][0] = -32'sh00030000;
        write_matrix(m);
        run_random(ITEMS_PER_PHASE);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
